// File: src/bfd_pkg.sv
package bfd_pkg;

    localparam int SUM_W = 20;
    localparam int PIX_W = 8;
    localparam int NUM_CH = 4;
    localparam int DIV_W = SUM_W + 1;
    localparam int CFG_DATA_W = 9;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_OUT_WIDTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FACTOR = 2'd2;

    // channel 0 red, 1 green, 2 blue, 3 alpha
    typedef logic [NUM_CH-1:0][PIX_W-1:0] pix_t;
    typedef logic [NUM_CH-1:0][SUM_W-1:0] sums_t;

    typedef struct packed {
        sums_t sums;
        logic  row_end;
        logic  frame_end;
    } job_t;

endpackage

// File: src/bfd_accum.sv
module bfd_accum
    import bfd_pkg::*;
#(
    parameter int MAX_WIDTH = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int MAX_FACTOR = 64,
    parameter int WW = $clog2(MAX_WIDTH + 1),
    parameter int HW = $clog2(MAX_HEIGHT + 1),
    parameter int FLW = $clog2(MAX_FACTOR + 1)
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           clear,
    input  logic [WW-1:0]  w_lim,
    input  logic [HW-1:0]  h_lim,
    input  logic [FLW-1:0] f_lim,
    input  logic           in_valid,
    output logic           in_ready,
    input  pix_t           in_pix,
    output logic           job_valid,
    input  logic           job_ready,
    output job_t           job
);

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int FW = (MAX_FACTOR > 1) ? $clog2(MAX_FACTOR) : 1;

    sums_t mem [MAX_WIDTH];

    logic [FW-1:0] sub_col_reg, sub_col_next;
    logic [FW-1:0] sub_row_reg, sub_row_next;
    logic [CW-1:0] out_col_reg, out_col_next;
    logic [RW-1:0] out_row_reg, out_row_next;

    logic          s1_valid_reg;
    logic [CW-1:0] s1_col_reg;
    pix_t          s1_pix_reg;
    logic          s1_first_reg;
    logic          s1_last_reg;
    logic          s1_row_end_reg;
    logic          s1_frame_end_reg;
    logic          fwd_hit_reg;
    sums_t         fwd_data_reg;
    sums_t         rd_data_reg;

    logic  accept;
    logic  s1_fire;
    logic  sc_end, oc_end, sr_end, or_end;
    sums_t s1_sum;
    sums_t base;

    assign sc_end = (FLW'(sub_col_reg) == f_lim - FLW'(1));
    assign sr_end = (FLW'(sub_row_reg) == f_lim - FLW'(1));
    assign oc_end = (WW'(out_col_reg) == w_lim - WW'(1));
    assign or_end = (HW'(out_row_reg) == h_lim - HW'(1));

    assign s1_fire = s1_valid_reg && (!s1_last_reg || job_ready);
    assign in_ready = !s1_valid_reg || s1_fire;
    assign accept = in_valid && in_ready;

    always_comb
    begin
        sub_col_next = sub_col_reg;
        out_col_next = out_col_reg;
        sub_row_next = sub_row_reg;
        out_row_next = out_row_reg;
        if (sc_end)
        begin
            sub_col_next = '0;
            if (oc_end)
            begin
                out_col_next = '0;
                if (sr_end)
                begin
                    sub_row_next = '0;
                    out_row_next = or_end ? '0 : out_row_reg + RW'(1);
                end
                else
                begin
                    sub_row_next = sub_row_reg + FW'(1);
                end
            end
            else
            begin
                out_col_next = out_col_reg + CW'(1);
            end
        end
        else
        begin
            sub_col_next = sub_col_reg + FW'(1);
        end
    end

    always_comb
    begin
        base = fwd_hit_reg ? fwd_data_reg : rd_data_reg;
        for (int c = 0; c < NUM_CH; c++)
        begin
            s1_sum[c] = s1_first_reg ? SUM_W'(s1_pix_reg[c])
                                     : base[c] + SUM_W'(s1_pix_reg[c]);
        end
    end

    assign job_valid = s1_valid_reg && s1_last_reg;
    assign job.sums = s1_sum;
    assign job.row_end = s1_row_end_reg;
    assign job.frame_end = s1_frame_end_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sub_col_reg <= '0;
            sub_row_reg <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            s1_valid_reg <= 1'b0;
            fwd_hit_reg <= 1'b0;
        end
        else
        begin
            if (clear)
            begin
                sub_col_reg <= '0;
                sub_row_reg <= '0;
                out_col_reg <= '0;
                out_row_reg <= '0;
            end
            else if (accept)
            begin
                sub_col_reg <= sub_col_next;
                sub_row_reg <= sub_row_next;
                out_col_reg <= out_col_next;
                out_row_reg <= out_row_next;
            end
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
                fwd_hit_reg <= s1_fire && (s1_col_reg == out_col_reg);
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    // word fields, read port and write-back
    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            mem[s1_col_reg] <= s1_sum;
        end
        if (accept)
        begin
            rd_data_reg <= mem[out_col_reg];
            fwd_data_reg <= s1_sum;
            s1_col_reg <= out_col_reg;
            s1_pix_reg <= in_pix;
            s1_first_reg <= (sub_col_reg == '0) && (sub_row_reg == '0);
            s1_last_reg <= sc_end && sr_end;
            s1_row_end_reg <= oc_end;
            s1_frame_end_reg <= oc_end && or_end;
        end
    end

endmodule

// File: src/bfd_div.sv
module bfd_div
    import bfd_pkg::*;
#(
    parameter int NW = 13
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [NW-1:0]    n,
    input  logic             job_valid,
    output logic             job_ready,
    input  job_t             job,
    output logic             out_valid,
    input  logic             out_ready,
    output pix_t             avg,
    output logic             row_end,
    output logic             frame_end
);

    localparam int QW = PIX_W;
    localparam int SW = $clog2(QW);
    localparam int XW = (DIV_W > NW + QW) ? DIV_W : NW + QW;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } state_t;

    state_t                           state_reg;
    logic [NUM_CH-1:0][DIV_W-1:0]     rem_reg;
    pix_t                             q_reg;
    logic [SW-1:0]                    step_reg;
    logic [NW-1:0]                    n_reg;
    logic                             row_end_reg;
    logic                             frame_end_reg;

    logic                             start;
    logic [XW-1:0]                    dsr;
    logic [NUM_CH-1:0]                ge;
    logic [NUM_CH-1:0][DIV_W-1:0]     rem_next;

    assign job_ready = (state_reg == ST_IDLE) || ((state_reg == ST_DONE) && out_ready);
    assign start = job_valid && job_ready;

    // one quotient bit per cycle, MSB first
    always_comb
    begin
        dsr = XW'(n_reg) << step_reg;
        for (int c = 0; c < NUM_CH; c++)
        begin
            ge[c] = (XW'(rem_reg[c]) >= dsr);
            rem_next[c] = ge[c] ? rem_reg[c] - DIV_W'(dsr) : rem_reg[c];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            rem_reg <= '0;
            q_reg <= '0;
            step_reg <= '0;
            n_reg <= '0;
            row_end_reg <= 1'b0;
            frame_end_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE, ST_DONE:
                begin
                    if (start)
                    begin
                        for (int c = 0; c < NUM_CH; c++)
                        begin
                            rem_reg[c] <= DIV_W'(job.sums[c]) + DIV_W'(n >> 1);
                        end
                        n_reg <= n;
                        step_reg <= SW'(QW - 1);
                        row_end_reg <= job.row_end;
                        frame_end_reg <= job.frame_end;
                        state_reg <= ST_RUN;
                    end
                    else if (state_reg == ST_DONE && out_ready)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_RUN:
                begin
                    rem_reg <= rem_next;
                    for (int c = 0; c < NUM_CH; c++)
                    begin
                        q_reg[c] <= {q_reg[c][QW-2:0], ge[c]};
                    end
                    step_reg <= step_reg - SW'(1);
                    if (step_reg == '0)
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid = (state_reg == ST_DONE);
    assign avg = q_reg;
    assign row_end = row_end_reg;
    assign frame_end = frame_end_reg;

endmodule

// File: src/box_filter_downsample_rgba.sv
// Box-filter downsampler for a supersampled RGBA raster stream.
// Input channel: in_valid/in_ready with red, green, blue, alpha; one subpixel
// per word in raster order, factor times wider and taller than the output.
// Output channel: out_valid/out_ready with the rounded block averages and the
// row_end / frame_end flags; one word per factor x factor block.
// Configuration: cfg_wr_en, cfg_index, cfg_data; 0 out_width, 1 out_height,
// 2 factor. A write to one of these restarts the frame position. Write only
// while idle. Throughput: one subpixel per cycle, except when a block
// completes while the divider still holds the previous block; the divider
// forms 8 quotient bits, one per cycle for all four channels, then holds the
// word in its done state until taken, so with factor 1 the input stalls on
// each word. The input keeps one subpixel per cycle while out_ready holds for
// factor 9 or more, or factor 3 or more with out_width 1. A block's last
// subpixel passes the accumulator stage and the divider's run and done states.
// Column sums live in a MAX_WIDTH-deep memory (one read, one write per cycle)
// with a forwarding path for back-to-back hits on the same column.
// Reset: position counters clear, registers return to 16, 16 and 4; the sum
// memory is not cleared (the first subpixel of each block loads it).
// A stalled output holds its word; the input stalls once the pipeline and the
// divider are both full.
module box_filter_downsample_rgba
    import bfd_pkg::*;
#(
    parameter int MAX_WIDTH = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int MAX_FACTOR = 64
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [PIX_W-1:0]      red,
    input  logic [PIX_W-1:0]      green,
    input  logic [PIX_W-1:0]      blue,
    input  logic [PIX_W-1:0]      alpha,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [PIX_W-1:0]      avg_red,
    output logic [PIX_W-1:0]      avg_green,
    output logic [PIX_W-1:0]      avg_blue,
    output logic [PIX_W-1:0]      avg_alpha,
    output logic                  row_end,
    output logic                  frame_end
);

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int FLW = $clog2(MAX_FACTOR + 1);
    localparam int NW = $clog2(MAX_FACTOR * MAX_FACTOR + 1);

    function automatic int unsigned clamp(int unsigned v, int unsigned hi);
        int unsigned r;
        r = v;
        if (v < 1)
        begin
            r = 1;
        end
        else if (v > hi)
        begin
            r = hi;
        end
        return r;
    endfunction

    localparam int unsigned W_RST = clamp(16, MAX_WIDTH);
    localparam int unsigned H_RST = clamp(16, MAX_HEIGHT);
    localparam int unsigned F_RST = clamp(4, MAX_FACTOR);

    logic [WW-1:0]  width_reg, width_next;
    logic [HW-1:0]  height_reg, height_next;
    logic [FLW-1:0] factor_reg, factor_next;
    logic [NW-1:0]  n_reg, n_next;
    logic           cfg_hit;

    pix_t in_pix;
    pix_t avg;
    job_t job;
    logic job_valid;
    logic job_ready;

    always_comb
    begin
        width_next = width_reg;
        height_next = height_reg;
        factor_next = factor_reg;
        cfg_hit = 1'b0;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_OUT_WIDTH:
                begin
                    width_next = WW'(clamp(int'(cfg_data), MAX_WIDTH));
                    cfg_hit = 1'b1;
                end
                REG_OUT_HEIGHT:
                begin
                    height_next = HW'(clamp(int'(cfg_data), MAX_HEIGHT));
                    cfg_hit = 1'b1;
                end
                REG_FACTOR:
                begin
                    factor_next = FLW'(clamp(int'(cfg_data[6:0]), MAX_FACTOR));
                    cfg_hit = 1'b1;
                end
                default:
                begin
                    cfg_hit = 1'b0;
                end
            endcase
        end
        n_next = NW'(NW'(factor_next) * NW'(factor_next));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= WW'(W_RST);
            height_reg <= HW'(H_RST);
            factor_reg <= FLW'(F_RST);
            n_reg <= NW'(F_RST * F_RST);
        end
        else
        begin
            width_reg <= width_next;
            height_reg <= height_next;
            factor_reg <= factor_next;
            n_reg <= n_next;
        end
    end

    assign in_pix = {alpha, blue, green, red};

    bfd_accum #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_FACTOR (MAX_FACTOR),
        .WW         (WW),
        .HW         (HW),
        .FLW        (FLW)
    ) u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear     (cfg_hit),
        .w_lim     (width_reg),
        .h_lim     (height_reg),
        .f_lim     (factor_reg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_pix    (in_pix),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job)
    );

    bfd_div #(
        .NW (NW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .n         (n_reg),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .avg       (avg),
        .row_end   (row_end),
        .frame_end (frame_end)
    );

    assign avg_red = avg[0];
    assign avg_green = avg[1];
    assign avg_blue = avg[2];
    assign avg_alpha = avg[3];

endmodule
